// File: sv/efc_pkg.sv
// Shared types and constants for the Ethernet frame classifier.
`timescale 1ns / 1ps
package efc_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       capture_end;
   } req_type;

   typedef struct packed {
      logic [31:0] frame_number;
      logic [2:0]  frame_kind;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [31:0] first_ip;
      logic [31:0] second_ip;
      logic [15:0] ip_data_size;
      logic [31:0] kind_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  frame_kind;
      logic [47:0] dest_mac;
      logic [47:0] src_mac;
      logic [31:0] first_ip;
      logic [31:0] second_ip;
      logic [15:0] ip_data_size;
   } hdr_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef enum logic [1:0] {
      PH_ZERO,
      PH_HEAD,
      PH_SKIP
   } phase_type;

   localparam int POS_BITS = 17;
   localparam int KIND_NUM = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = 1;

   localparam logic [2:0] KIND_IPV4 = 3'd0;
   localparam logic [2:0] KIND_ARP  = 3'd1;
   localparam logic [2:0] KIND_DIX  = 3'd2;
   localparam logic [2:0] KIND_RAW  = 3'd3;
   localparam logic [2:0] KIND_SNAP = 3'd4;
   localparam logic [2:0] KIND_LLC  = 3'd5;

   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [15:0] ETH_ARP    = 16'h0806;
   localparam logic [15:0] LLC_RAW    = 16'hFFFF;
   localparam logic [15:0] LLC_SNAP   = 16'hAAAA;
   localparam logic [15:0] MAX_LENGTH = 16'd1500;
   localparam logic [15:0] HDR_BYTES  = 16'd14;

   localparam logic [POS_BITS-1:0] MAC_BYTES     = 17'd6;
   localparam logic [POS_BITS-1:0] POS_LT_HI     = 17'd12;
   localparam logic [POS_BITS-1:0] POS_LT_LO     = 17'd13;
   localparam logic [POS_BITS-1:0] POS_LLC_HI    = 17'd14;
   localparam logic [POS_BITS-1:0] POS_LLC_LO    = 17'd15;
   localparam logic [POS_BITS-1:0] POS_IPLEN_HI  = 17'd16;
   localparam logic [POS_BITS-1:0] POS_IPLEN_LO  = 17'd17;
   localparam logic [POS_BITS-1:0] POS_IP4_SRC_A = 17'd26;
   localparam logic [POS_BITS-1:0] POS_IP4_SRC_B = 17'd29;
   localparam logic [POS_BITS-1:0] POS_IP4_DST_A = 17'd30;
   localparam logic [POS_BITS-1:0] POS_IP4_DST_B = 17'd33;
   localparam logic [POS_BITS-1:0] POS_ARP_SND_A = 17'd28;
   localparam logic [POS_BITS-1:0] POS_ARP_SND_B = 17'd31;
   localparam logic [POS_BITS-1:0] POS_ARP_TGT_A = 17'd38;
   localparam logic [POS_BITS-1:0] POS_ARP_TGT_B = 17'd41;
   localparam logic [POS_BITS-1:0] ARP_END       = 17'd42;

endpackage

// File: sv/ethernet_frame_classifier_core.sv
// Top level of the Ethernet frame classifier: parser, record queue and counter stage.
//
//   port group   direction  carries
//   req_*        in         one capture byte and its end-of-capture flag per request
//   rsp_*        out        one classification record per recognized frame header
//
// One byte request is taken each cycle while req_stall is low; the parser handles it
// in the cycle it arrives. A record enters the two-entry queue on its last header byte
// and appears on rsp_* in the cycle after it leaves the queue. reset clears the parser
// state, the queue and all counters. req_stall rises only while the queue is full;
// rsp_stall holds the output register and lets the queue fill behind it.
`timescale 1ns / 1ps
module ethernet_frame_classifier_core #(
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  efc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output efc_pkg::rsp_type rsp_payload
);
   import efc_pkg::*;

   q_status_type q_status;
   logic         hdr_push;
   hdr_type      hdr_data;
   hdr_type      head_data;
   logic         q_pop;

   efc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .hdr_push    (hdr_push),
      .hdr_data    (hdr_data)
   );

   efc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hdr_push),
      .push_data (hdr_data),
      .pop       (q_pop),
      .head_data (head_data),
      .status    (q_status)
   );

   efc_tally #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tally (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_data   (head_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/efc_parser.sv
// Byte parser: drops zero groups, captures the header and emits one record per frame whose header completes.
`timescale 1ns / 1ps
module efc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  efc_pkg::req_type      req_payload,
   input  efc_pkg::q_status_type q_status,
   output logic                  hdr_push,
   output efc_pkg::hdr_type      hdr_data
);
   import efc_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [47:0]           pend_ff, pend_in;
   logic [47:0]           dest_ff, dest_in;
   logic [47:0]           src_ff, src_in;
   logic [15:0]           lt_ff, lt_in;
   logic [15:0]           llc_ff, llc_in;
   logic [15:0]           iplen_ff, iplen_in;
   logic [31:0]           fip_ff, fip_in;
   logic [31:0]           sip_ff, sip_in;
   logic [POS_BITS-1:0]   fend_ff, fend_in;

   logic                  take;
   logic [7:0]            b;
   logic [POS_BITS-1:0]   pos_inc;
   logic [15:0]           lt_cur;
   logic [15:0]           llc_cur;
   logic [31:0]           sip_cur;
   logic [47:0]           pend_cur;
   logic                  is_ip4, is_arp, is_dix;
   logic                  head_done;
   logic [2:0]            kind;
   logic [POS_BITS-1:0]   end_raw, end_raised;
   logic                  head_skip;
   logic                  zero_full, zero_hit;
   logic                  skip_done;
   logic                  restart;

   assign req_stall = q_status.full;
   assign take      = req_valid && !req_stall;
   assign b         = req_payload.byte_value;

   always_comb begin
      pos_inc  = POS_BITS'(pos_ff + 1'b1);
      lt_cur   = ((pos_ff == POS_LT_HI) || (pos_ff == POS_LT_LO)) ? {lt_ff[7:0], b} : lt_ff;
      llc_cur  = {llc_ff[7:0], b};
      sip_cur  = {sip_ff[23:0], b};
      pend_cur = {pend_ff[39:0], b};
      is_ip4   = (lt_cur == ETH_IPV4);
      is_arp   = (lt_cur == ETH_ARP);
      is_dix   = !is_ip4 && !is_arp && (lt_cur > MAX_LENGTH);
      head_done = 1'b0;
      kind      = KIND_DIX;
      end_raw   = '0;
      if (is_ip4) begin
         head_done = (pos_ff == POS_IP4_DST_B);
         kind      = KIND_IPV4;
         end_raw   = POS_BITS'(16'(iplen_ff + HDR_BYTES));
      end else if (is_arp) begin
         head_done = (pos_ff == POS_ARP_TGT_B);
         kind      = KIND_ARP;
         end_raw   = ARP_END;
      end else if (is_dix) begin
         head_done = (pos_ff == POS_LT_LO);
         kind      = KIND_DIX;
         end_raw   = POS_BITS'(lt_cur) + POS_BITS'(HDR_BYTES);
      end else begin
         head_done = (pos_ff == POS_LLC_LO);
         end_raw   = POS_BITS'(lt_cur) + POS_BITS'(HDR_BYTES);
         if (llc_cur == LLC_RAW) begin
            kind = KIND_RAW;
         end else if (llc_cur == LLC_SNAP) begin
            kind = KIND_SNAP;
         end else begin
            kind = KIND_LLC;
         end
      end
      end_raised = (end_raw < pos_inc) ? pos_inc : end_raw;
      head_skip  = (end_raised > pos_inc);
      zero_full  = (pos_inc == MAC_BYTES);
      zero_hit   = zero_full && (pend_cur != '0);
      skip_done  = (pos_inc >= fend_ff);
      restart    = req_payload.capture_end
                   || ((phase_ff == PH_HEAD) && head_done && !head_skip)
                   || ((phase_ff == PH_SKIP) && skip_done);
   end

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_ZERO: begin
               if (zero_hit) begin
                  phase_in = PH_HEAD;
               end
            end
            PH_HEAD: begin
               if (head_done && head_skip) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            default: begin
               phase_in = PH_ZERO;
            end
         endcase
         if (restart) begin
            phase_in = PH_ZERO;
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      pend_in  = pend_ff;
      dest_in  = dest_ff;
      src_in   = src_ff;
      lt_in    = lt_ff;
      llc_in   = llc_ff;
      iplen_in = iplen_ff;
      fip_in   = fip_ff;
      sip_in   = sip_ff;
      fend_in  = fend_ff;
      hdr_push = 1'b0;
      hdr_data.frame_kind   = kind;
      hdr_data.dest_mac     = dest_ff;
      hdr_data.src_mac      = src_ff;
      hdr_data.first_ip     = (kind == KIND_IPV4 || kind == KIND_ARP) ? fip_ff : '0;
      hdr_data.second_ip    = (kind == KIND_IPV4 || kind == KIND_ARP) ? sip_cur : '0;
      hdr_data.ip_data_size = (kind == KIND_IPV4) ? 16'(iplen_ff + HDR_BYTES) : '0;
      if (take) begin
         pos_in = pos_inc;
         case (phase_ff)
            PH_ZERO: begin
               pend_in = pend_cur;
               if (zero_full) begin
                  if (zero_hit) begin
                     dest_in = pend_cur;
                     pend_in = '0;
                  end else begin
                     pos_in = '0;
                  end
               end
            end
            PH_HEAD: begin
               if (pos_ff < POS_LT_HI) begin
                  src_in = {src_ff[39:0], b};
               end else if (pos_ff == POS_LT_HI || pos_ff == POS_LT_LO) begin
                  lt_in = lt_cur;
               end else if (lt_ff == ETH_IPV4) begin
                  if (pos_ff == POS_IPLEN_HI || pos_ff == POS_IPLEN_LO) begin
                     iplen_in = {iplen_ff[7:0], b};
                  end else if (pos_ff >= POS_IP4_SRC_A && pos_ff <= POS_IP4_SRC_B) begin
                     fip_in = {fip_ff[23:0], b};
                  end else if (pos_ff >= POS_IP4_DST_A && pos_ff <= POS_IP4_DST_B) begin
                     sip_in = sip_cur;
                  end
               end else if (lt_ff == ETH_ARP) begin
                  if (pos_ff >= POS_ARP_SND_A && pos_ff <= POS_ARP_SND_B) begin
                     fip_in = {fip_ff[23:0], b};
                  end else if (pos_ff >= POS_ARP_TGT_A && pos_ff <= POS_ARP_TGT_B) begin
                     sip_in = sip_cur;
                  end
               end else if (lt_ff <= MAX_LENGTH) begin
                  if (pos_ff == POS_LLC_HI || pos_ff == POS_LLC_LO) begin
                     llc_in = llc_cur;
                  end
               end
               if (head_done) begin
                  hdr_push = 1'b1;
                  fend_in  = end_raised;
               end
            end
            PH_SKIP: begin
               pos_in = pos_inc;
            end
            default: begin
               pos_in = '0;
            end
         endcase
         if (restart) begin
            pos_in  = '0;
            pend_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ZERO;
         pos_ff   <= '0;
         pend_ff  <= '0;
         fend_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
         fend_ff  <= fend_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff  <= dest_in;
      src_ff   <= src_in;
      lt_ff    <= lt_in;
      llc_ff   <= llc_in;
      iplen_ff <= iplen_in;
      fip_ff   <= fip_in;
      sip_ff   <= sip_in;
   end

endmodule

// File: sv/efc_queue.sv
// Short record queue between the parser and the counter stage.
`timescale 1ns / 1ps
module efc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  efc_pkg::hdr_type      push_data,
   input  logic                  pop,
   output efc_pkg::hdr_type      head_data,
   output efc_pkg::q_status_type status
);
   import efc_pkg::*;

   hdr_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QPTR_BITS:0]     cnt_ff, cnt_in;
   logic                   do_pop;

   assign do_pop           = pop && (cnt_ff != '0);
   assign head_data        = mem_ff[rd_ff];
   assign status.full      = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign status.not_empty = (cnt_ff != '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(rd_ff + 1'b1);
      end
      if (push && !do_pop) begin
         cnt_in = (QPTR_BITS+1)'(cnt_ff + 1'b1);
      end else if (do_pop && !push) begin
         cnt_in = (QPTR_BITS+1)'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/efc_tally.sv
// Counter stage: numbers each record, counts it by kind and holds the result.
`timescale 1ns / 1ps
module efc_tally #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  efc_pkg::q_status_type q_status,
   input  efc_pkg::hdr_type      head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output efc_pkg::rsp_type      rsp_payload
);
   import efc_pkg::*;

   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] kcnt_ff [KIND_NUM];
   logic [COUNT_BITS-1:0] kcnt_in [KIND_NUM];
   logic [COUNT_BITS-1:0] kind_next;
   logic                  vld_ff, vld_in;
   rsp_type               rsp_ff, rsp_in;

   assign pop         = q_status.not_empty && (!vld_ff || !rsp_stall);
   assign rsp_valid   = vld_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      total_in  = total_ff;
      kind_next = '0;
      vld_in    = vld_ff && rsp_stall;
      rsp_in    = rsp_ff;
      for (int i = 0; i < KIND_NUM; i++) begin
         kcnt_in[i] = kcnt_ff[i];
         if (head_data.frame_kind == 3'(i)) begin
            kind_next = COUNT_BITS'(kcnt_ff[i] + 1'b1);
         end
      end
      if (pop) begin
         total_in = COUNT_BITS'(total_ff + 1'b1);
         for (int i = 0; i < KIND_NUM; i++) begin
            if (head_data.frame_kind == 3'(i)) begin
               kcnt_in[i] = kind_next;
            end
         end
         vld_in              = 1'b1;
         rsp_in.frame_number = 32'(total_in);
         rsp_in.frame_kind   = head_data.frame_kind;
         rsp_in.dest_mac     = head_data.dest_mac;
         rsp_in.src_mac      = head_data.src_mac;
         rsp_in.first_ip     = head_data.first_ip;
         rsp_in.second_ip    = head_data.second_ip;
         rsp_in.ip_data_size = head_data.ip_data_size;
         rsp_in.kind_count   = 32'(kind_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         vld_ff   <= 1'b0;
         for (int i = 0; i < KIND_NUM; i++) begin
            kcnt_ff[i] <= '0;
         end
      end else begin
         total_ff <= total_in;
         vld_ff   <= vld_in;
         for (int i = 0; i < KIND_NUM; i++) begin
            kcnt_ff[i] <= kcnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// File: verif/testbench.sv
// Testbench for the Ethernet frame classifier: predicts each frame record from the byte stream and checks it.
`timescale 1ns / 1ps
module testbench;
   import efc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IPV4_HEAD = POS_IP4_DST_B + 1;
   localparam int LLC_HEAD = POS_LLC_LO + 1;
   localparam int LONG_HOLD = 300;

   class frame_record_board;
      phase_type         phase;
      logic [16:0]       pos;
      logic [16:0]       frame_end;
      logic [47:0]       zero_acc;
      logic [47:0]       dest;
      logic [47:0]       src;
      logic [15:0]       lt;
      logic [15:0]       llc;
      logic [15:0]       ip_len;
      logic [31:0]       ip_a;
      logic [31:0]       ip_b;
      logic [31:0]       kind_tally [KIND_NUM];
      logic [31:0]       frame_tally;
      rsp_type           expected_records [$];
      int unsigned       mismatches;
      int unsigned       records_checked;

      function new();
         restart();
         dest = '0;
         src = '0;
         lt = '0;
         llc = '0;
         ip_len = '0;
         ip_a = '0;
         ip_b = '0;
         frame_end = '0;
         foreach (kind_tally[k]) kind_tally[k] = '0;
         frame_tally = '0;
         mismatches = 0;
         records_checked = 0;
      endfunction

      function void restart();
         phase = PH_ZERO;
         pos = '0;
         zero_acc = '0;
      endfunction

      function void note_byte(req_type item);
         logic [7:0]  b;
         logic [16:0] p;
         logic [16:0] end_pos;
         logic [2:0]  kind;
         bit          done;
         rsp_type     rec;
         b = item.byte_value;
         done = 1'b0;
         kind = KIND_IPV4;
         end_pos = '0;
         case (phase)
            PH_HEAD: begin
               p = pos;
               pos = pos + 1'b1;
               if (p < POS_LT_HI) begin
                  src = {src[39:0], b};
               end else if (p <= POS_LT_LO) begin
                  lt = {lt[7:0], b};
               end else if (lt == ETH_IPV4) begin
                  if (p == POS_IPLEN_HI || p == POS_IPLEN_LO)
                     ip_len = {ip_len[7:0], b};
                  else if (p >= POS_IP4_SRC_A && p <= POS_IP4_SRC_B)
                     ip_a = {ip_a[23:0], b};
                  else if (p >= POS_IP4_DST_A && p <= POS_IP4_DST_B)
                     ip_b = {ip_b[23:0], b};
               end else if (lt == ETH_ARP) begin
                  if (p >= POS_ARP_SND_A && p <= POS_ARP_SND_B)
                     ip_a = {ip_a[23:0], b};
                  else if (p >= POS_ARP_TGT_A && p <= POS_ARP_TGT_B)
                     ip_b = {ip_b[23:0], b};
               end else if (lt <= MAX_LENGTH) begin
                  if (p == POS_LLC_HI || p == POS_LLC_LO)
                     llc = {llc[7:0], b};
               end

               if (p >= POS_LT_LO) begin
                  if (lt == ETH_IPV4) begin
                     if (p == POS_IP4_DST_B) begin
                        done = 1'b1;
                        kind = KIND_IPV4;
                        end_pos = {1'b0, 16'(ip_len + HDR_BYTES)};
                     end
                  end else if (lt == ETH_ARP) begin
                     if (p == POS_ARP_TGT_B) begin
                        done = 1'b1;
                        kind = KIND_ARP;
                        end_pos = ARP_END;
                     end
                  end else if (lt > MAX_LENGTH) begin
                     if (p == POS_LT_LO) begin
                        done = 1'b1;
                        kind = KIND_DIX;
                        end_pos = {1'b0, lt} + {1'b0, HDR_BYTES};
                     end
                  end else if (p == POS_LLC_LO) begin
                     done = 1'b1;
                     end_pos = {1'b0, lt} + {1'b0, HDR_BYTES};
                     if (llc == LLC_RAW) kind = KIND_RAW;
                     else if (llc == LLC_SNAP) kind = KIND_SNAP;
                     else kind = KIND_LLC;
                  end
               end

               if (done) begin
                  frame_tally = frame_tally + 1'b1;
                  kind_tally[kind] = kind_tally[kind] + 1'b1;
                  rec.frame_number = frame_tally;
                  rec.frame_kind = kind;
                  rec.dest_mac = dest;
                  rec.src_mac = src;
                  rec.first_ip = (kind == KIND_IPV4 || kind == KIND_ARP) ? ip_a : '0;
                  rec.second_ip = (kind == KIND_IPV4 || kind == KIND_ARP) ? ip_b : '0;
                  rec.ip_data_size = (kind == KIND_IPV4) ? 16'(ip_len + HDR_BYTES) : '0;
                  rec.kind_count = kind_tally[kind];
                  expected_records.push_back(rec);
                  if (end_pos < pos) end_pos = pos;
                  frame_end = end_pos;
                  if (frame_end > pos) phase = PH_SKIP;
                  else restart();
               end
            end
            PH_SKIP: begin
               pos = pos + 1'b1;
               if (pos >= frame_end) restart();
            end
            default: begin
               zero_acc = {zero_acc[39:0], b};
               pos = pos + 1'b1;
               if (pos >= MAC_BYTES) begin
                  if (zero_acc == '0) begin
                     pos = '0;
                  end else begin
                     dest = zero_acc;
                     zero_acc = '0;
                     phase = PH_HEAD;
                  end
               end
            end
         endcase
         if (item.capture_end) restart();
      endfunction

      function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field_name, want, got);
            mismatches++;
         end
      endfunction

      function void check_record(rsp_type got);
         rsp_type want;
         if (expected_records.size() == 0) begin
            $error("frame record arrived with none expected: frame_number %0h",
                   got.frame_number);
            mismatches++;
            return;
         end
         want = expected_records.pop_front();
         records_checked++;
         compare_field("frame_number", want.frame_number, got.frame_number);
         compare_field("frame_kind", want.frame_kind, got.frame_kind);
         compare_field("dest_mac", want.dest_mac, got.dest_mac);
         compare_field("src_mac", want.src_mac, got.src_mac);
         compare_field("first_ip", want.first_ip, got.first_ip);
         compare_field("second_ip", want.second_ip, got.second_ip);
         compare_field("ip_data_size", want.ip_data_size, got.ip_data_size);
         compare_field("kind_count", want.kind_count, got.kind_count);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   frame_record_board board;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_request = 1'b0;
   int      hold_left = 0;
   int      bytes_sent = 0;
   int      cycle_count = 0;
   int      failures;

   ethernet_frame_classifier_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_record(rsp_payload);
      if (hold_request) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value, input bit last);
      req_type item;
      item.byte_value = value;
      item.capture_end = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(item);
      bytes_sent++;
   endtask

   task automatic wait_for_records();
      req_valid <= 1'b0;
      while (board.expected_records.size() != 0) @(posedge clock);
   endtask

   task automatic send_frame(input int zero_groups, input logic [47:0] dmac,
                             input logic [15:0] kind_word, input logic [15:0] second_word,
                             input logic [15:0] ip_total, input int body_len, input bit cut);
      logic [7:0]  frame_bytes [$];
      logic [47:0] smac;
      logic [7:0]  value;
      smac = 48'({$urandom, $urandom});
      repeat (6 * zero_groups) frame_bytes.push_back(8'h00);
      for (int i = 5; i >= 0; i--) frame_bytes.push_back(dmac[8*i +: 8]);
      for (int i = 5; i >= 0; i--) frame_bytes.push_back(smac[8*i +: 8]);
      frame_bytes.push_back(kind_word[15:8]);
      frame_bytes.push_back(kind_word[7:0]);
      for (int offset = HDR_BYTES; offset < HDR_BYTES + body_len; offset++) begin
         case (offset)
            POS_LLC_HI:   value = second_word[15:8];
            POS_LLC_LO:   value = second_word[7:0];
            POS_IPLEN_HI: value = ip_total[15:8];
            POS_IPLEN_LO: value = ip_total[7:0];
            default:      value = 8'($urandom);
         endcase
         frame_bytes.push_back(value);
      end
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i], cut && i == frame_bytes.size() - 1);
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) send_byte(8'($urandom), i == count - 1);
   endtask

   task automatic send_random_frame();
      int          pick;
      int          zero_groups;
      int          body_len;
      int          end_pos;
      logic [47:0] dmac;
      logic [15:0] kind_word;
      logic [15:0] second_word;
      logic [15:0] ip_total;
      bit          cut;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_noise();
         return;
      end
      zero_groups = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      dmac = 48'({$urandom, $urandom});
      dmac = dmac >> (8 * $urandom_range(0, 5));
      if (dmac == '0) dmac = 48'h1;
      second_word = 16'($urandom);
      ip_total = 16'($urandom);
      cut = 1'b0;
      if (pick < 30) begin
         kind_word = ETH_IPV4;
         ip_total = ($urandom_range(9) == 0) ? 16'($urandom_range(65521, 65535))
                                             : 16'($urandom_range(0, 60));
         end_pos = (int'(ip_total) + HDR_BYTES) % 65536;
         if (end_pos < IPV4_HEAD) end_pos = IPV4_HEAD;
         body_len = end_pos - HDR_BYTES;
      end else if (pick < 48) begin
         kind_word = ETH_ARP;
         body_len = ARP_END - HDR_BYTES;
      end else if (pick < 66) begin
         kind_word = 16'($urandom_range(MAX_LENGTH + 1, 65535));
         if (kind_word == ETH_IPV4 || kind_word == ETH_ARP) kind_word = kind_word ^ 16'h0100;
         body_len = $urandom_range(0, 12);
         cut = 1'b1;
      end else begin
         kind_word = 16'($urandom_range(0, 40));
         case ($urandom_range(2))
            0: second_word = LLC_RAW;
            1: second_word = LLC_SNAP;
            default: ;
         endcase
         body_len = (kind_word < LLC_HEAD - HDR_BYTES) ? LLC_HEAD - HDR_BYTES : kind_word;
      end
      if (!cut && $urandom_range(7) == 0) begin
         cut = 1'b1;
         body_len = $urandom_range(0, body_len);
      end
      send_frame(zero_groups, dmac, kind_word, second_word, ip_total, body_len, cut);
   endtask

   initial begin
      int          target;
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_frame(2, 48'h0000_0000_0001, ETH_IPV4, 16'h4500, 16'd20,
                 IPV4_HEAD - HDR_BYTES, 1'b0);
      send_frame(0, 48'hFFFF_FFFF_FFFF, ETH_ARP, 16'h0001, 16'h0800,
                 ARP_END - HDR_BYTES, 1'b0);
      send_frame(0, 48'h0102_0304_0506, MAX_LENGTH + 16'd1, 16'h0, 16'h0, 0, 1'b1);
      send_frame(1, 48'h8000_0000_0000, 16'hFFFF, 16'h0, 16'h0, 3, 1'b1);
      send_frame(0, 48'({$urandom, $urandom}) | 48'h1, 16'd0, LLC_RAW, 16'h0,
                 LLC_HEAD - HDR_BYTES, 1'b0);
      send_frame(0, 48'({$urandom, $urandom}) | 48'h1, 16'd5, LLC_SNAP, 16'h0, 5, 1'b0);
      send_frame(0, 48'({$urandom, $urandom}) | 48'h1, MAX_LENGTH, 16'h0303, 16'h0,
                 LLC_HEAD - HDR_BYTES, 1'b1);
      send_frame(0, 48'({$urandom, $urandom}) | 48'h1, ETH_IPV4, 16'h0, 16'hFFFF,
                 IPV4_HEAD - HDR_BYTES, 1'b0);
      send_frame(0, 48'({$urandom, $urandom}) | 48'h1, ETH_IPV4, 16'h0, 16'd100, 10, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_for_records();

      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin send_idle_pct = 35; recv_stall_pct = 83; end
            1: begin send_idle_pct = 83; recv_stall_pct = 35; end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         target = bytes_sent + 270;
         while (bytes_sent < target)
            send_random_frame();
         wait_for_records();
      end

      repeat (20) @(posedge clock);
      failures = board.mismatches;
      if (board.expected_records.size() != 0) begin
         $error("%0d frame records never arrived", board.expected_records.size());
         failures += board.expected_records.size();
      end
      $display("Run covered %0d capture bytes and %0d frame records checked",
               bytes_sent, board.records_checked);
      $display("  by kind: IPv4 %0d, ARP %0d, DIX %0d, RAW %0d, SNAP %0d, LLC %0d",
               board.kind_tally[KIND_IPV4], board.kind_tally[KIND_ARP],
               board.kind_tally[KIND_DIX], board.kind_tally[KIND_RAW],
               board.kind_tally[KIND_SNAP], board.kind_tally[KIND_LLC]);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
